// File: rtl/masked_rect_region_stats_unit_defines.svh
// Assertion macros shared by the block's RTL.
`ifndef MASKED_RECT_REGION_STATS_UNIT_DEFINES_SVH
`define MASKED_RECT_REGION_STATS_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MRRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MRRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mrrs_pkg.sv
package mrrs_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 25;
  localparam int SUM_W    = 41;
  localparam int COL_W    = 12;
  localparam int ROW_W    = 12;
  localparam int RLEN_W   = 13;
  localparam int CFG_W    = 24;
  localparam int DIFF_W   = 18;
  localparam int PROD_W   = 42;
  localparam int QSUM_W   = 43;
  localparam int DIVD_W   = 40;

  localparam logic [COUNT_W-1:0]        COUNT_FULL = '1;
  localparam logic signed [QSUM_W-1:0]  UNIT_Q24   = QSUM_W'(64'sd16777216);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [RLEN_W-1:0] RLEN_MAX = RLEN_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int DIV_STEPS  = DIVD_W;
  localparam int DIV_STEP_W = 6;

  // Configuration register indexes.
  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_COEF_XX    = 3'd2;
  localparam logic [2:0] REG_COEF_XY    = 3'd3;
  localparam logic [2:0] REG_COEF_YX    = 3'd4;
  localparam logic [2:0] REG_COEF_YY    = 3'd5;
  localparam logic [2:0] REG_INVERT     = 3'd6;
  localparam logic [2:0] REG_ROW_LENGTH = 3'd7;

  typedef struct packed {
    logic signed [16:0]       center_x;
    logic signed [16:0]       center_y;
    logic signed [CFG_W-1:0]  coef_xx;
    logic signed [CFG_W-1:0]  coef_xy;
    logic signed [CFG_W-1:0]  coef_yx;
    logic signed [CFG_W-1:0]  coef_yy;
    logic                     invert;
    logic [RLEN_W-1:0]        row_length;
  } cfg_t;

  // Frame totals handed from the pixel pipeline to the divider.
  typedef struct packed {
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] min;
    logic signed [SAMPLE_W-1:0] max;
    logic signed [SUM_W-1:0]    sum;
  } stats_rec_t;

endpackage

// File: rtl/mrrs_pixel_if.sv
interface mrrs_pixel_if import mrrs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_end;

  modport source (output valid, sample, frame_end, input ready);
  modport sink (input valid, sample, frame_end, output ready);
endinterface

// File: rtl/mrrs_stats_if.sv
interface mrrs_stats_if import mrrs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [COUNT_W-1:0]         pixel_count;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [SAMPLE_W-1:0] maximum;
  logic signed [SAMPLE_W-1:0] mean;

  modport source (output valid, pixel_count, minimum, maximum, mean, input ready);
  modport sink (input valid, pixel_count, minimum, maximum, mean, output ready);
endinterface

// File: rtl/masked_rect_region_stats_unit.sv
// Region statistics over a raster-scanned image under a rotated-rectangle mask.
// Input channel pix_i carries one signed pixel per item in raster order, with
// frame_end set on the last pixel. The block counts column and row itself.
// Output channel res_o carries one item per frame: selected pixel count,
// minimum, maximum and the mean truncated toward zero.
// Configuration (center, matrix, invert, row length) is written through the
// cfg_we_i / cfg_index_i / cfg_wdata_i port. The user must write it only while
// no frame is in progress; the block itself does not enforce this. Pixels are
// taken one per cycle. A pixel passes a three-stage mask and accumulate
// pipeline; on frame end the totals enter a four-entry queue. A bit-serial
// divider takes totals from that queue and forms the mean by restoring division.
// Frames ending while the divider is busy fill the queue; pixel input stalls when
// no queue slot is left for a frame end already in the pipeline.
// When the receiver holds res_o.ready low, the result stays on the port and
// the queue keeps collecting later frames.
// Reset clears position, totals, queue and divider, and loads the default
// configuration (unit matrix, center at the origin, rows of 4096 pixels).
`include "masked_rect_region_stats_unit_defines.svh"

module masked_rect_region_stats_unit import mrrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  mrrs_pixel_if.sink       pix_i,
  mrrs_stats_if.source     res_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic push, pop, q_empty;
  logic [QCNT_W-1:0] q_free;
  stats_rec_t push_rec, head_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x   <= '0;
      cfg_q.center_y   <= '0;
      cfg_q.coef_xx    <= 24'sd1048576;
      cfg_q.coef_xy    <= '0;
      cfg_q.coef_yx    <= '0;
      cfg_q.coef_yy    <= 24'sd1048576;
      cfg_q.invert     <= 1'b0;
      cfg_q.row_length <= RLEN_MAX;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CENTER_X:   cfg_q.center_x   <= cfg_wdata_i[16:0];
        REG_CENTER_Y:   cfg_q.center_y   <= cfg_wdata_i[16:0];
        REG_COEF_XX:    cfg_q.coef_xx    <= cfg_wdata_i;
        REG_COEF_XY:    cfg_q.coef_xy    <= cfg_wdata_i;
        REG_COEF_YX:    cfg_q.coef_yx    <= cfg_wdata_i;
        REG_COEF_YY:    cfg_q.coef_yy    <= cfg_wdata_i;
        REG_INVERT:     cfg_q.invert     <= cfg_wdata_i[0];
        REG_ROW_LENGTH: cfg_q.row_length <= cfg_wdata_i[RLEN_W-1:0];
        default: ;
      endcase
    end
  end

  mrrs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pix_i  (pix_i),
    .free_i (q_free),
    .push_o (push),
    .rec_o  (push_rec)
  );

  mrrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .rec_o   (head_rec),
    .empty_o (q_empty),
    .free_o  (q_free)
  );

  mrrs_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (head_rec),
    .empty_i (q_empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

  `MRRS_ASSERT_NOW(a_push_has_room, clk_i, rst_ni, push, q_free != '0, "frame totals pushed into a full queue")
  `MRRS_ASSERT_NOW(a_pop_not_empty, clk_i, rst_ni, pop, !q_empty, "divider took totals from an empty queue")
  `MRRS_ASSERT_NOW(a_empty_frame, clk_i, rst_ni, res_o.valid && res_o.pixel_count == '0, res_o.mean == '0 && res_o.minimum == SAMPLE_MAX && res_o.maximum == SAMPLE_MIN, "empty selection gave nonzero mean or moved extremes")
  `MRRS_ASSERT_NEXT(a_stall_blocks_pop, clk_i, rst_ni, res_o.valid && !res_o.ready, !pop, "divider took new totals while a result was still held")

endmodule

// File: rtl/mrrs_front.sv
module mrrs_front import mrrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  mrrs_pixel_if.sink        pix_i,
  input  logic [QCNT_W-1:0] free_i,
  output logic              push_o,
  output stats_rec_t        rec_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [RLEN_W-1:0] rlen;
  logic accept;
  logic [1:0] inflight;

  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_last_q, s2_last_q, s3_last_q;
  logic signed [SAMPLE_W-1:0] s1_smp_q, s2_smp_q, s3_smp_q;
  logic signed [DIFF_W-1:0] d0, d1, s1_d0_q, s1_d1_q;
  logic signed [PROD_W-1:0] p_xx_q, p_xy_q, p_yx_q, p_yy_q;
  logic signed [QSUM_W-1:0] q0, q1;
  logic in_rect, s3_sel_q;

  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic signed [SAMPLE_W-1:0] min_q, min_d, max_q, max_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic hit;

  // Each frame end still in the pipeline needs a queue slot kept free for it.
  assign inflight = {1'b0, s1_v_q & s1_last_q} + {1'b0, s2_v_q & s2_last_q}
                  + {1'b0, s3_v_q & s3_last_q};
  assign pix_i.ready = {1'b0, inflight} < free_i;
  assign accept = pix_i.valid && pix_i.ready;

  assign rlen = (cfg_i.row_length == '0 || cfg_i.row_length > RLEN_MAX) ?
                RLEN_MAX : cfg_i.row_length;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (pix_i.frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if ({1'b0, col_q} + RLEN_W'(1) >= rlen) begin
        col_d = '0;
        row_d = (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  assign d0 = $signed({2'b00, col_q, 4'b0000}) - {cfg_i.center_x[16], cfg_i.center_x};
  assign d1 = $signed({2'b00, row_q, 4'b0000}) - {cfg_i.center_y[16], cfg_i.center_y};

  assign q0 = {p_xx_q[PROD_W-1], p_xx_q} + {p_xy_q[PROD_W-1], p_xy_q};
  assign q1 = {p_yx_q[PROD_W-1], p_yx_q} + {p_yy_q[PROD_W-1], p_yy_q};
  assign in_rect = (q0 >= -UNIT_Q24) && (q0 <= UNIT_Q24) &&
                   (q1 >= -UNIT_Q24) && (q1 <= UNIT_Q24);

  // Selected pixels stop counting once the count saturates.
  assign hit = s3_v_q && s3_sel_q && (cnt_q != COUNT_FULL);

  always_comb begin
    cnt_d = cnt_q;
    min_d = min_q;
    max_d = max_q;
    sum_d = sum_q;
    if (hit) begin
      cnt_d = cnt_q + COUNT_W'(1);
      if (s3_smp_q < min_q) begin
        min_d = s3_smp_q;
      end
      if (s3_smp_q > max_q) begin
        max_d = s3_smp_q;
      end
      sum_d = sum_q + SUM_W'(s3_smp_q);
    end
  end

  assign push_o = s3_v_q && s3_last_q;
  assign rec_o  = '{count: cnt_d, min: min_d, max: max_d, sum: sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      cnt_q  <= '0;
      min_q  <= SAMPLE_MAX;
      max_q  <= SAMPLE_MIN;
      sum_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (push_o) begin
        cnt_q <= '0;
        min_q <= SAMPLE_MAX;
        max_q <= SAMPLE_MIN;
        sum_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        min_q <= min_d;
        max_q <= max_d;
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_d0_q   <= d0;
    s1_d1_q   <= d1;
    s1_smp_q  <= pix_i.sample;
    s1_last_q <= pix_i.frame_end;
    p_xx_q    <= s1_d0_q * cfg_i.coef_xx;
    p_xy_q    <= s1_d1_q * cfg_i.coef_xy;
    p_yx_q    <= s1_d0_q * cfg_i.coef_yx;
    p_yy_q    <= s1_d1_q * cfg_i.coef_yy;
    s2_smp_q  <= s1_smp_q;
    s2_last_q <= s1_last_q;
    s3_sel_q  <= cfg_i.invert ? !in_rect : in_rect;
    s3_smp_q  <= s2_smp_q;
    s3_last_q <= s2_last_q;
  end

endmodule

// File: rtl/mrrs_queue.sv
module mrrs_queue import mrrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stats_rec_t        rec_i,
  input  logic              pop_i,
  output stats_rec_t        rec_o,
  output logic              empty_o,
  output logic [QCNT_W-1:0] free_o
);

  stats_rec_t entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign rec_o   = entry_q[rd_q];
  assign empty_o = cnt_q == '0;
  assign free_o  = QCNT_W'(QDEPTH) - cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= rec_i;
    end
  end

endmodule

// File: rtl/mrrs_divider.sv
module mrrs_divider import mrrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stats_rec_t  rec_i,
  input  logic        empty_i,
  output logic        pop_o,
  mrrs_stats_if.source res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic [DIV_STEP_W-1:0] step_q;
  logic [DIVD_W-1:0] quo_q;
  logic [COUNT_W-1:0] rem_q, cnt_q;
  logic signed [SAMPLE_W-1:0] min_q, max_q, mean_q;
  logic neg_q;
  logic [COUNT_W:0] trial, diff;
  logic fits;
  logic [DIVD_W-1:0] mag;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  // Magnitude of the sum is below 2^40 since the count saturates below 2^25.
  assign mag = DIVD_W'(rec_i.sum[SUM_W-1] ? -rec_i.sum : rec_i.sum);

  // Restoring division of the sum magnitude by the count, one bit per cycle.
  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign diff  = trial - {1'b0, cnt_q};
  assign fits  = trial >= {1'b0, cnt_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cnt_q  <= rec_i.count;
      min_q  <= rec_i.min;
      max_q  <= rec_i.max;
      neg_q  <= rec_i.sum[SUM_W-1];
      quo_q  <= mag;
      rem_q  <= '0;
      step_q <= '0;
    end else if (state_q == ST_BUSY) begin
      rem_q  <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo_q  <= {quo_q[DIVD_W-2:0], fits};
      step_q <= step_q + DIV_STEP_W'(1);
    end
    if (state_q == ST_BUSY && state_d == ST_DONE) begin
      // The last quotient bit lands this cycle, so form the mean from it here.
      if (cnt_q == '0) begin
        mean_q <= '0;
      end else if (neg_q) begin
        mean_q <= -$signed({quo_q[SAMPLE_W-2:0], fits});
      end else begin
        mean_q <= $signed({quo_q[SAMPLE_W-2:0], fits});
      end
    end
  end

  assign res_o.valid       = state_q == ST_DONE;
  assign res_o.pixel_count = cnt_q;
  assign res_o.minimum     = min_q;
  assign res_o.maximum     = max_q;
  assign res_o.mean        = mean_q;

endmodule
